>>> rtl/core/s256bh_pkg.sv
`default_nettype none
package s256bh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_byte;   // shift a byte into the block and count it
        logic       pad_byte;    // shift a padding byte (marker or zero)
        logic       pad_marker;  // padding byte is 0x80
        logic       len_byte;    // shift one length byte
        logic       start;       // load working vars, start 64 rounds
        logic       round;       // one round
        logic       finish;      // add working vars into chaining value
        logic       msg_reset;   // back to initial hash, zero fill and bit counts
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [5:0] fill;
        logic       last_round;
    } dp_stat_t;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/s256bh_datapath.sv
`default_nettype none
module s256bh_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire s256bh_pkg::dp_cmd_t  cmd,
    input  wire logic [7:0]           byte_in,
    output s256bh_pkg::dp_stat_t      stat,
    output logic [255:0]              hash
);
    import s256bh_pkg::*;

    // 16-word message schedule window, kept as a byte shift line
    logic [511:0] win_reg, win_next;
    logic [255:0] h_reg, h_next;
    logic [255:0] v_reg, v_next;
    logic [5:0]   fill_reg, fill_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [63:0]  bits_reg, bits_next;

    logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] big0, big1, ch, maj, t1, t2;
    logic [7:0]  len_b, shift_b;

    always_comb
    begin
        w0  = win_reg[511:480];
        w1  = win_reg[479:448];
        w9  = win_reg[223:192];
        w14 = win_reg[63:32];
        s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
        s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
        w_new = w0 + s0 + w9 + s1;
        {a, b, c, d, e, f, g, h} = v_reg;
        big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch   = (e & f) ^ (~e & g);
        t1   = h + big1 + ch + round_k(rnd_reg) + w0;
        big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        maj  = (a & b) ^ (a & c) ^ (b & c);
        t2   = big0 + maj;
        len_b = bits_reg[63:56];
    end

    always_comb
    begin
        win_next  = win_reg;
        h_next    = h_reg;
        v_next    = v_reg;
        fill_next = fill_reg;
        rnd_next  = rnd_reg;
        bits_next = bits_reg;
        shift_b   = 8'h00;
        if (cmd.load_byte)
            shift_b = byte_in;
        else if (cmd.pad_byte && cmd.pad_marker)
            shift_b = PAD_MARKER;
        else if (cmd.len_byte)
            shift_b = len_b;
        if (cmd.load_byte || cmd.pad_byte || cmd.len_byte) begin
            win_next  = {win_reg[503:0], shift_b};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.load_byte)
            bits_next = bits_reg + 64'd8;
        if (cmd.len_byte)
            bits_next = {bits_reg[55:0], len_b};  // rotates back after 8 bytes
        if (cmd.start) begin
            v_next   = h_reg;
            rnd_next = 6'd0;
        end
        if (cmd.round) begin
            v_next   = {t1 + t2, a, b, c, d + t1, e, f, g};
            win_next = {win_reg[479:0], w_new};
            rnd_next = rnd_reg + 6'd1;
        end
        if (cmd.finish) begin
            for (int i = 0; i < 8; i++)
                h_next[i*32 +: 32] = h_reg[i*32 +: 32] + v_reg[i*32 +: 32];
        end
        if (cmd.msg_reset) begin
            h_next    = INIT_H;
            fill_next = 6'd0;
            bits_next = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            h_reg    <= INIT_H;
            fill_reg <= 6'd0;
            rnd_reg  <= 6'd0;
            bits_reg <= 64'd0;
        end else begin
            h_reg    <= h_next;
            fill_reg <= fill_next;
            rnd_reg  <= rnd_next;
            bits_reg <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        v_reg   <= v_next;
    end

    assign stat.fill       = fill_reg;
    assign stat.last_round = (rnd_reg == 6'd63);
    assign hash            = h_reg;
endmodule
`default_nettype wire

>>> rtl/core/s256bh_ctrl.sv
`default_nettype none
module s256bh_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire s256bh_pkg::in_item_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output s256bh_pkg::out_item_t      out_data,
    output s256bh_pkg::dp_cmd_t        cmd,
    input  wire s256bh_pkg::dp_stat_t  stat,
    input  wire logic [255:0]          hash
);
    import s256bh_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_START  = 8'b0000_0010,
        S_ROUND  = 8'b0000_0100,
        S_FINISH = 8'b0000_1000,
        S_MARK   = 8'b0001_0000,
        S_ZERO   = 8'b0010_0000,
        S_LEN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;     // message is ending, marker still to go
    logic       mark_reg, mark_next;   // marker placed, padding under way
    logic       final_reg, final_next; // this compression is the last one
    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        mark_next  = mark_reg;
        final_next = final_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
                if (take) begin
                    cmd.load_byte = in_data.has_byte;
                    fin_next      = in_data.is_last;
                    if (in_data.has_byte && stat.fill == 6'd63)
                        state_next = S_START;
                    else if (in_data.is_last)
                        state_next = S_MARK;
                end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.last_round)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (final_reg) begin
                    final_next = 1'b0;
                    mark_next  = 1'b0;
                    idx_next   = 2'd0;
                    state_next = S_OUT;
                end else if (mark_reg)
                    state_next = S_ZERO;
                else if (fin_reg)
                    state_next = S_MARK;
                else
                    state_next = S_IDLE;
            end
            S_MARK:
            begin
                // marker after the message bytes; at fill 63 it closes the block
                cmd.pad_byte   = 1'b1;
                cmd.pad_marker = 1'b1;
                fin_next       = 1'b0;
                mark_next      = 1'b1;
                state_next     = (stat.fill == 6'd63) ? S_START : S_ZERO;
            end
            S_ZERO:
            begin
                if (stat.fill == LENGTH_POS) begin
                    state_next = S_LEN;
                end else begin
                    cmd.pad_byte = 1'b1;
                    if (stat.fill == 6'd63)
                        state_next = S_START;
                end
            end
            S_LEN:
            begin
                cmd.len_byte = 1'b1;
                if (stat.fill == 6'd63) begin
                    final_next = 1'b1;
                    state_next = S_START;
                end
            end
            S_OUT:
                if (out_ready) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        cmd.msg_reset = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            final_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            mark_reg  <= mark_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        out_valid            = (state_reg == S_OUT);
        out_data.digest_word = hash[255 - {idx_reg, 6'd0} -: 64];
        out_data.word_index  = idx_reg;
        out_data.last_word   = (idx_reg == 2'd3);
    end
endmodule
`default_nettype wire

>>> rtl/core/sha256_byte_stream_hasher_core.sv
// A plain byte is shifted in and in_ready stays high; a byte that fills a block
//   adds a compression (start, 64 rounds at one per cycle in the shared round
//   unit, final add). A last beat pads the block byte by byte with one or two
//   compressions, then four digest beats, one per cycle while the sink is ready.
// One item at a time: in_ready is low during compression, padding and output.
// rst_n (async, active low) loads the initial hash and clears counts and control.
`default_nettype none
module sha256_byte_stream_hasher_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire s256bh_pkg::in_item_t   in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output s256bh_pkg::out_item_t       out_data
);
    import s256bh_pkg::*;

    dp_cmd_t      cmd;
    dp_stat_t     stat;
    logic [255:0] hash;

    // controller for handshakes, padding sequence, round sequencing and digest beats
    s256bh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat),
        .hash      (hash)
    );

    // datapath: block shift line doubles as the schedule window, one round/cycle
    s256bh_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .byte_in (in_data.data_byte),
        .stat    (stat),
        .hash    (hash)
    );
endmodule
`default_nettype wire

>>> rtl/core/s256bh_checker.sv
`default_nettype none
module s256bh_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire s256bh_pkg::out_item_t out_data
);
    import s256bh_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("digest beat dropped or changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while digest pending");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word |=>
            out_valid && out_data.word_index == $past(out_data.word_index) + 2'd1)
        else $error("digest beats out of order");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.last_word == (out_data.word_index == 2'd3))
        else $error("last_word mismatch");
endmodule

bind sha256_byte_stream_hasher_core s256bh_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

>>> test/sha256_byte_stream_hasher_core_test.sv
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_core_test;
    import s256bh_pkg::*;

    // ---------------------------------------------------------------
    // Clock and reset: 10 ns period, reset held low from the start, released on a falling edge
    // ---------------------------------------------------------------
    logic clk;
    logic rst_n;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    sha256_byte_stream_hasher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ---------------------------------------------------------------
    // Digest predictor: own copy of chaining value, block and length
    // ---------------------------------------------------------------
    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0] hash_h [8];
    logic [7:0]  blk [64];
    logic [5:0]  blk_fill;
    logic [63:0] msg_bits;

    out_item_t digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_message();
        hash_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        blk_fill = '0;
        msg_bits = '0;
    endtask

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = hash_h;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_h[i] += v[i];
    endtask

    // Feed one accepted beat; a last beat queues the four digest words
    task automatic predict_beat(input in_item_t it);
        out_item_t o;
        if (it.has_byte)
        begin
            blk[blk_fill] = it.data_byte;
            msg_bits += 64'd8;
            blk_fill++;
            if (blk_fill == 6'd0)
                compress();
        end
        if (it.is_last)
        begin
            blk[blk_fill] = PAD_MARKER;
            // marker in the last 8 bytes: length spills into a second block
            if (blk_fill >= LENGTH_POS)
            begin
                for (int i = blk_fill + 1; i < 64; i++)
                    blk[i] = 8'h00;
                compress();
                for (int i = 0; i < 56; i++)
                    blk[i] = 8'h00;
            end
            else
            begin
                for (int i = blk_fill + 1; i < 56; i++)
                    blk[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                blk[56 + i] = msg_bits[63 - 8*i -: 8];
            compress();
            for (int k = 0; k < 4; k++)
            begin
                o.digest_word = {hash_h[2*k], hash_h[2*k+1]};
                o.word_index  = 2'(k);
                o.last_word   = (k == 3);
                digest_q = {digest_q, o};
            end
            restart_message();
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus: directed table first, then random messages
    // ---------------------------------------------------------------
    in_item_t stim_q [$];
    // Digest words typed in for the empty message (known SHA-256 of "")
    logic [63:0] empty_digest [4] = '{64'he3b0c44298fc1c14, 64'h9afbf4c8996fb924,
                                      64'h27ae41e4649b934c, 64'ha495991b7852b855};
    logic        known_hit;
    int          words_seen;
    bit          failed;
    bit          calm;           // no idling on either side while set
    int          quiet_cycles;

    task automatic add_beat(input logic [7:0] b, input logic hb, input logic lst);
        in_item_t it;
        it.data_byte = b;
        it.has_byte  = hb;
        it.is_last   = lst;
        stim_q = {stim_q, it};
    endtask

    task automatic add_message(input int len, input bit last_carries, input bit noise);
        for (int i = 0; i < len; i++)
        begin
            if (noise && $urandom_range(0, 9) == 0)
                add_beat(8'($urandom), 1'b0, 1'b0);   // no byte, not last: ignored
            add_beat(8'($urandom), 1'b1, (i == len - 1) && last_carries);
        end
        if (!last_carries || len == 0)
            add_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        calm      = 1'b0;
        failed    = 1'b0;
        words_seen = 0;
        restart_message();

        // Directed rows: empty message, extremes of the byte, a lone ignored
        // beat, byte and last together, last without a byte, and a walking one
        add_beat(8'hff, 1'b0, 1'b1);                  // empty message
        add_beat(8'h00, 1'b0, 1'b0);                  // ignored
        add_beat(8'h00, 1'b1, 1'b0);
        add_beat(8'hff, 1'b1, 1'b1);                  // byte and last together
        add_beat(8'h5a, 1'b1, 1'b0);
        add_beat(8'ha5, 1'b1, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1);                  // last without a byte
        for (int i = 0; i < 8; i++)
            add_beat(8'(1 << i), 1'b1, i == 7);
        // random messages follow, some of them near block edges, some empty
        while (stim_q.size() < 245)
        begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(54, 57);      // one or two final blocks
                1: len = $urandom_range(63, 65);      // around an exact block fill
                2: len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            add_message(len, 1'($urandom_range(0, 1)), 1'b1);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < stim_q.size(); n++)
        begin
            calm = (n >= 120 && n < 170);
            while (!calm && $urandom_range(0, 99) < 32)
                @(negedge clk);
            in_data  = stim_q[n];
            in_valid = 1'b1;
            do
                @(posedge clk);
            while (!in_ready);
            predict_beat(stim_q[n]);
            @(negedge clk);
            in_valid = 1'b0;
        end

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sink stall pattern, changed on the falling edge
    always @(negedge clk)
        out_ready <= rst_n && (calm || $urandom_range(0, 99) >= 32);

    // ---------------------------------------------------------------
    // Result check on the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("digest beat with nothing expected: %h", out_data);
                failed = 1'b1;
            end
            else
            begin
                want = digest_q.pop_front();
                // the very first message is the empty one: its digest is known
                known_hit = (words_seen < 4);
                if (known_hit && want.digest_word != empty_digest[words_seen])
                begin
                    $error("digest_word (empty message): expected %h actual %h",
                           empty_digest[words_seen], want.digest_word);
                    failed = 1'b1;
                end
                if (out_data.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h actual %h",
                           want.digest_word, out_data.digest_word);
                    failed = 1'b1;
                end
                if (out_data.word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d actual %0d",
                           want.word_index, out_data.word_index);
                    failed = 1'b1;
                end
                if (out_data.last_word !== want.last_word)
                begin
                    $error("last_word: expected %0d actual %0d",
                           want.last_word, out_data.last_word);
                    failed = 1'b1;
                end
            end
            words_seen++;
        end
    end

    // Watchdog: cycles without any beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/s256bh_pkg.sv
rtl/core/s256bh_datapath.sv
rtl/core/s256bh_ctrl.sv
rtl/core/sha256_byte_stream_hasher_core.sv
rtl/core/s256bh_checker.sv
test/sha256_byte_stream_hasher_core_test.sv
